// ===== src/sleep_wakeup_timer_table_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the sleep/wakeup timer table
// Clocked on i_clk, disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SLEEP_WAKEUP_TIMER_TABLE_MACROS_SVH
`define SLEEP_WAKEUP_TIMER_TABLE_MACROS_SVH

// Same-cycle implication.
`define SWT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("swt assertion failed");

// Next-cycle implication.
`define SWT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("swt assertion failed");

`endif

// ===== src/swt_pkg.sv =====
// ---------------------------------------------------------------------------
// swt_pkg
// Types and constants shared by the sleep/wakeup timer table.
// ---------------------------------------------------------------------------
package swt_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int TIME_W          = 32;
    localparam int THREAD_W        = 8;

    localparam logic CMD_SLEEP = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    typedef struct packed {
        logic                cmd;
        logic [THREAD_W-1:0] thread_id;
        logic [TIME_W-1:0]   delay_ticks;
        logic                cpu_idle;
        logic                future_interrupts;
    } t_in_item;

    typedef struct packed {
        logic                woke_valid;
        logic [THREAD_W-1:0] woke_thread;
        logic                table_full;
        logic                yield_on_return;
        logic                timer_off;
        logic                last;
    } t_out_item;

endpackage

// ===== src/sleep_wakeup_timer_table.sv =====
// ---------------------------------------------------------------------------
// sleep_wakeup_timer_table
// Table of sleeping thread ids with wake times, driven by sleep and tick
// transactions.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one command per
//   transaction: sleep stores a thread with wake time = time + delay, tick
//   advances time by one and releases every entry whose time has come.
//   Output channel (o_out_valid / i_out_ready / o_out_data) returns results:
//   a sleep gives one result (table_full on overflow); a tick gives one result
//   per woken thread in entry order, then a closing result with the
//   yield_on_return / timer_off flags. Every command ends on a result with
//   last set.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes
//   priority_mode; it is always ready.
// Timing:
//   Sleep: one used bit tested per cycle in the free-entry scan. Tick: one
//   RAM entry read per cycle via the single read port. Both stop at an entry
//   with a result while the result register is held. A new command is taken
//   once the previous one has placed its last result in the output register.
// Reset clears the time, the used bits and priority_mode; no clearing pass.
// A stalled receiver holds the result register and stops the sweep at a due entry.
// ---------------------------------------------------------------------------
module sleep_wakeup_timer_table #(
    parameter int TABLE_DEPTH = swt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  swt_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output swt_pkg::t_out_item  o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data
);

    import swt_pkg::*;

    localparam int IW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int RAM_W = TIME_W + THREAD_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SLEEP = 2'd1;
    localparam logic [1:0] ST_TICK  = 2'd2;
    localparam logic [1:0] ST_CLOSE = 2'd3;

    logic [1:0]             r_state, n_state;
    logic [IW-1:0]          r_idx, n_idx;
    logic [TABLE_DEPTH-1:0] r_used, n_used;
    logic [TIME_W-1:0]      r_time, n_time;
    logic                   r_woke, n_woke;
    logic                   r_empty, n_empty;
    logic                   r_prio;
    t_in_item               r_cmd;
    t_out_item              r_out;
    logic                   r_out_valid;

    logic                   in_acc;
    logic                   out_free;
    logic                   emit;
    t_out_item              res;
    logic                   last_idx;
    logic                   ram_we;
    logic [RAM_W-1:0]       ram_wdata;
    logic [RAM_W-1:0]       ram_rdata;
    logic [TIME_W-1:0]      rd_wake;
    logic [THREAD_W-1:0]    rd_thread;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign last_idx    = (r_idx == IW'(TABLE_DEPTH - 1));
    assign ram_wdata   = {r_time + r_cmd.delay_ticks, r_cmd.thread_id};
    assign rd_wake     = ram_rdata[RAM_W-1:THREAD_W];
    assign rd_thread   = ram_rdata[THREAD_W-1:0];
    assign o_cfg_ready = 1'b1;

    // Read address follows the next index, so data for r_idx is ready in
    // the cycle r_idx is current; a stall re-reads the same entry.
    swt_ram #(
        .WIDTH (RAM_W),
        .DEPTH (TABLE_DEPTH)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (ram_wdata),
        .i_raddr (n_idx),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_used  = r_used;
        n_time  = r_time;
        n_woke  = r_woke;
        n_empty = r_empty;
        emit    = 1'b0;
        ram_we  = 1'b0;
        res     = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_idx = '0;
                    if (i_in_data.cmd == CMD_SLEEP) begin
                        n_state = ST_SLEEP;
                    end else begin
                        n_time  = r_time + TIME_W'(1);
                        n_woke  = 1'b0;
                        n_empty = 1'b1;
                        n_state = ST_TICK;
                    end
                end
            end
            ST_SLEEP: begin
                if (!r_used[r_idx]) begin
                    if (out_free) begin
                        ram_we        = 1'b1;
                        n_used[r_idx] = 1'b1;
                        emit          = 1'b1;
                        res.last      = 1'b1;
                        n_state       = ST_IDLE;
                    end
                end else if (last_idx) begin
                    if (out_free) begin
                        emit           = 1'b1;
                        res.table_full = 1'b1;
                        res.last       = 1'b1;
                        n_state        = ST_IDLE;
                    end
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            ST_TICK: begin
                if (r_used[r_idx] && (rd_wake <= r_time)) begin
                    // hold the sweep until the result register frees up
                    if (out_free) begin
                        emit            = 1'b1;
                        res.woke_valid  = 1'b1;
                        res.woke_thread = rd_thread;
                        n_used[r_idx]   = 1'b0;
                        n_woke          = 1'b1;
                        if (last_idx) begin
                            n_state = ST_CLOSE;
                        end else begin
                            n_idx = r_idx + IW'(1);
                        end
                    end
                end else begin
                    if (r_used[r_idx]) begin
                        n_empty = 1'b0;
                    end
                    if (last_idx) begin
                        n_state = ST_CLOSE;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end
            ST_CLOSE: begin
                if (out_free) begin
                    emit     = 1'b1;
                    res.last = 1'b1;
                    if (!r_woke && r_empty && r_cmd.cpu_idle) begin
                        res.timer_off = !r_cmd.future_interrupts;
                    end else begin
                        res.yield_on_return = r_prio;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_used      <= '0;
            r_time      <= '0;
            r_woke      <= 1'b0;
            r_empty     <= 1'b1;
            r_prio      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_used  <= n_used;
            r_time  <= n_time;
            r_woke  <= n_woke;
            r_empty <= n_empty;
            if (i_cfg_valid) begin
                r_prio <= i_cfg_data;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd <= i_in_data;
        end
        if (emit) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`include "sleep_wakeup_timer_table_macros.svh"

    `SWT_ASSERT_NEXT(a_tick_advances_time, in_acc && (i_in_data.cmd == CMD_TICK), r_time == $past(r_time) + TIME_W'(1))
    `SWT_ASSERT_NEXT(a_woke_frees_entry, emit && res.woke_valid, !r_used[$past(r_idx)])
    `SWT_ASSERT_NEXT(a_sleep_claims_entry, emit && (r_state == ST_SLEEP) && !res.table_full, r_used[$past(r_idx)])
    `SWT_ASSERT_IMPL(a_no_result_when_idle, r_state == ST_IDLE, !emit)

endmodule

// ===== src/swt_ram.sv =====
// ---------------------------------------------------------------------------
// swt_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module swt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
